@@ design/rec_pkg.sv @@
// Shared types, constants and codes for the read extent coalescer.
`timescale 1ns / 1ps
package rec_pkg;

    localparam int MAX_SLABS = 64;
    localparam int IDX_W     = ($clog2(MAX_SLABS) > 6) ? $clog2(MAX_SLABS) : 6;
    localparam int CNT_W     = $clog2(MAX_SLABS + 1);
    localparam int CFG_W     = 49;
    localparam int END_W     = 49;
    localparam int THR_W     = 50;
    localparam int GAPK_W    = 59;
    localparam logic [19:0] BW_DEFAULT = 20'd3000;
    localparam logic [GAPK_W-1:0] NS_PER_BYTE_SCALE = GAPK_W'(1000);

    typedef enum logic [2:0] {
        REG_MAX_GAP    = 3'd0,
        REG_MAX_EXTENT = 3'd1,
        REG_SUBMIT     = 3'd2,
        REG_BANDWIDTH  = 3'd3,
        REG_ACROSS_SEC = 3'd4,
        REG_ACROSS_FIL = 3'd5,
        REG_ONE_PER    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0]      file;
        logic [47:0]      offset;
        logic [31:0]      length;
        logic [7:0]       section;
        logic [IDX_W-1:0] idx;
    } slab_t;

    typedef struct packed {
        logic  valid;
        slab_t data;
    } entry_t;

    typedef struct packed {
        logic [47:0]      max_gap;
        logic [48:0]      max_extent;
        logic [THR_W-1:0] cost_thr;
        logic             across_sec;
        logic             across_file;
        logic             one_per;
    } cfg_t;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] count;
    } plan_ctl_t;

    typedef struct packed {
        logic pop;
        logic finish;
    } plan_stat_t;

    typedef enum logic [1:0] {
        T_LOAD,
        T_SETTLE,
        T_PLAN
    } top_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_POP,
        M_CALC,
        M_CHECK,
        M_DECIDE,
        M_FLUSH
    } merge_state_t;

endpackage

@@ design/rec_cell.sv @@
// One cell of the insertion sort chain: holds the smallest item seen, passes the rest right.
`timescale 1ns / 1ps
module rec_cell
    import rec_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift_en,
    input  entry_t in_left,
    input  entry_t from_right,
    output entry_t held_out,
    output entry_t pass_out
);

    logic  held_valid_reg, held_valid_next;
    slab_t held_data_reg, held_data_next;
    logic  pass_valid_reg, pass_valid_next;
    slab_t pass_data_reg, pass_data_next;
    logic  in_smaller;

    // key is offset then arrival index, so equal offsets keep arrival order
    assign in_smaller = {in_left.data.offset, in_left.data.idx}
                      < {held_data_reg.offset, held_data_reg.idx};

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_data_next  = held_data_reg;
        pass_valid_next = 1'b0;
        pass_data_next  = pass_data_reg;
        if (shift_en)
        begin
            held_valid_next = from_right.valid;
            held_data_next  = from_right.data;
        end
        else if (in_left.valid)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next = 1'b1;
                held_data_next  = in_left.data;
            end
            else if (in_smaller)
            begin
                held_data_next  = in_left.data;
                pass_valid_next = 1'b1;
                pass_data_next  = held_data_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
                pass_data_next  = in_left.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_data_reg <= held_data_next;
        pass_data_reg <= pass_data_next;
    end

    assign held_out = '{valid: held_valid_reg, data: held_data_reg};
    assign pass_out = '{valid: pass_valid_reg, data: pass_data_reg};

endmodule

@@ design/rec_merge.sv @@
// Merge sequencer: walks the sorted items, grows extents and drives the results.
`timescale 1ns / 1ps
module rec_merge
    import rec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  plan_ctl_t   ctl,
    input  cfg_t        cfg,
    input  slab_t       head,
    output plan_stat_t  stat,
    output logic        result_valid,
    output logic [5:0]  slab_index,
    output logic [5:0]  extent_index,
    output logic        extent_done,
    output logic [15:0] extent_file,
    output logic [47:0] extent_offset,
    output logic [48:0] extent_size,
    output logic [54:0] planned_bytes,
    output logic [54:0] gap_total,
    output logic [37:0] requested_bytes,
    output logic        last_result
);

    merge_state_t state_reg, state_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic first_reg, first_next;
    slab_t cand_reg, cand_next;
    logic [END_W-1:0] gap_reg, gap_next;
    logic [END_W-1:0] nend_reg, nend_next;
    logic [48:0] nsize_reg, nsize_next;
    logic ok_reg, ok_next;

    logic [15:0] ext_file_reg, ext_file_next;
    logic [7:0] ext_sec_reg, ext_sec_next;
    logic [47:0] ext_start_reg, ext_start_next;
    logic [END_W-1:0] ext_end_reg, ext_end_next;
    logic [48:0] ext_size_reg, ext_size_next;
    logic [5:0] ext_no_reg, ext_no_next;
    logic can_merge_reg, can_merge_next;
    logic [IDX_W-1:0] prev_idx_reg, prev_idx_next;
    logic [54:0] planned_reg, planned_next;
    logic [54:0] gaps_reg, gaps_next;
    logic [37:0] req_reg, req_next;

    logic rv_reg, rv_next;
    logic [5:0] si_reg, si_next, ei_reg, ei_next;
    logic ed_reg, ed_next, lr_reg, lr_next;
    logic [15:0] ef_reg, ef_next;
    logic [47:0] eo_reg, eo_next;
    logic [48:0] es_reg, es_next;
    logic [54:0] pb_reg, pb_next, gt_reg, gt_next;
    logic [37:0] rb_reg, rb_next;

    logic [END_W-1:0] cand_off_w, cand_end_w;
    logic [GAPK_W-1:0] gap_scaled;

    assign cand_off_w = END_W'(cand_reg.offset);
    assign cand_end_w = END_W'(cand_reg.offset) + END_W'(cand_reg.length);
    assign gap_scaled = GAPK_W'(gap_reg) * NS_PER_BYTE_SCALE;

    always_comb
    begin
        state_next     = state_reg;
        remain_next    = remain_reg;
        first_next     = first_reg;
        cand_next      = cand_reg;
        gap_next       = gap_reg;
        nend_next      = nend_reg;
        nsize_next     = nsize_reg;
        ok_next        = ok_reg;
        ext_file_next  = ext_file_reg;
        ext_sec_next   = ext_sec_reg;
        ext_start_next = ext_start_reg;
        ext_end_next   = ext_end_reg;
        ext_size_next  = ext_size_reg;
        ext_no_next    = ext_no_reg;
        can_merge_next = can_merge_reg;
        prev_idx_next  = prev_idx_reg;
        planned_next   = planned_reg;
        gaps_next      = gaps_reg;
        req_next       = req_reg;
        rv_next = 1'b0;
        si_next = si_reg;
        ei_next = ei_reg;
        ed_next = ed_reg;
        lr_next = 1'b0;
        ef_next = ef_reg;
        eo_next = eo_reg;
        es_next = es_reg;
        pb_next = pb_reg;
        gt_next = gt_reg;
        rb_next = rb_reg;
        stat.pop    = 1'b0;
        stat.finish = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (ctl.go)
                begin
                    remain_next  = ctl.count;
                    first_next   = 1'b1;
                    ext_no_next  = '0;
                    planned_next = '0;
                    gaps_next    = '0;
                    req_next     = '0;
                    state_next   = M_POP;
                end
            end
            M_POP:
            begin
                stat.pop    = 1'b1;
                cand_next   = head;
                remain_next = remain_reg - CNT_W'(1);
                state_next  = M_CALC;
            end
            M_CALC:
            begin
                gap_next   = (cand_off_w > ext_end_reg) ? cand_off_w - ext_end_reg : '0;
                nend_next  = (cand_end_w < ext_end_reg) ? ext_end_reg : cand_end_w;
                state_next = M_CHECK;
            end
            M_CHECK:
            begin
                nsize_next = 49'(nend_reg - END_W'(ext_start_reg));
                ok_next = can_merge_reg
                        && (cfg.across_sec || cand_reg.section == ext_sec_reg)
                        && (cfg.across_file || cand_reg.file == ext_file_reg)
                        && (gap_reg <= END_W'(cfg.max_gap))
                        && (gap_reg == '0 || gap_scaled < GAPK_W'(cfg.cost_thr))
                        && (49'(nend_reg - END_W'(ext_start_reg)) <= cfg.max_extent);
                state_next = M_DECIDE;
            end
            M_DECIDE:
            begin
                req_next      = req_reg + 38'(cand_reg.length);
                prev_idx_next = cand_reg.idx;
                first_next    = 1'b0;
                if (!first_reg)
                begin
                    rv_next = 1'b1;
                    si_next = prev_idx_reg[5:0];
                    ei_next = ext_no_reg;
                    ed_next = !ok_reg;
                    ef_next = ok_reg ? 16'd0 : ext_file_reg;
                    eo_next = ok_reg ? 48'd0 : ext_start_reg;
                    es_next = ok_reg ? 49'd0 : ext_size_reg;
                    pb_next = '0;
                    gt_next = '0;
                    rb_next = '0;
                end
                if (!first_reg && ok_reg)
                begin
                    ext_end_next  = nend_reg;
                    ext_size_next = nsize_reg;
                    gaps_next     = gaps_reg + 55'(gap_reg);
                end
                else
                begin
                    if (!first_reg)
                    begin
                        planned_next = planned_reg + 55'(ext_size_reg);
                        ext_no_next  = ext_no_reg + 6'd1;
                    end
                    ext_file_next  = cand_reg.file;
                    ext_sec_next   = cand_reg.section;
                    ext_start_next = cand_reg.offset;
                    ext_end_next   = cand_end_w;
                    ext_size_next  = 49'(cand_reg.length);
                    can_merge_next = !cfg.one_per && (49'(cand_reg.length) <= cfg.max_extent);
                end
                state_next = (remain_reg == '0) ? M_FLUSH : M_POP;
            end
            M_FLUSH:
            begin
                rv_next = 1'b1;
                si_next = prev_idx_reg[5:0];
                ei_next = ext_no_reg;
                ed_next = 1'b1;
                ef_next = ext_file_reg;
                eo_next = ext_start_reg;
                es_next = ext_size_reg;
                pb_next = planned_reg + 55'(ext_size_reg);
                gt_next = gaps_reg;
                rb_next = req_reg;
                lr_next = 1'b1;
                stat.finish = 1'b1;
                state_next  = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            rv_reg    <= 1'b0;
            lr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            lr_reg    <= lr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg    <= remain_next;
        first_reg     <= first_next;
        cand_reg      <= cand_next;
        gap_reg       <= gap_next;
        nend_reg      <= nend_next;
        nsize_reg     <= nsize_next;
        ok_reg        <= ok_next;
        ext_file_reg  <= ext_file_next;
        ext_sec_reg   <= ext_sec_next;
        ext_start_reg <= ext_start_next;
        ext_end_reg   <= ext_end_next;
        ext_size_reg  <= ext_size_next;
        ext_no_reg    <= ext_no_next;
        can_merge_reg <= can_merge_next;
        prev_idx_reg  <= prev_idx_next;
        planned_reg   <= planned_next;
        gaps_reg      <= gaps_next;
        req_reg       <= req_next;
        si_reg <= si_next;
        ei_reg <= ei_next;
        ed_reg <= ed_next;
        ef_reg <= ef_next;
        eo_reg <= eo_next;
        es_reg <= es_next;
        pb_reg <= pb_next;
        gt_reg <= gt_next;
        rb_reg <= rb_next;
    end

    assign result_valid    = rv_reg;
    assign slab_index      = si_reg;
    assign extent_index    = ei_reg;
    assign extent_done     = ed_reg;
    assign extent_file     = ef_reg;
    assign extent_offset   = eo_reg;
    assign extent_size     = es_reg;
    assign planned_bytes   = pb_reg;
    assign gap_total       = gt_reg;
    assign requested_bytes = rb_reg;
    assign last_result     = lr_reg;

endmodule

@@ design/read_extent_coalescer.sv @@
// Top level: loader, configuration registers, sort chain and merge sequencer.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------------
//  item in  | start & !busy                | slab_file/offset/length/section, last_slab
//  result   | result_valid (one cycle)     | slab_index ... last_result
//  config   | cfg_write                    | cfg_index, cfg_data
//
// Loading takes one item per cycle while busy is low; each item ripples into place along
// the cell chain. After the last item the chain settles, then the merge sequencer pops
// the items one at a time, each through pop, calc, check and decide states.
// busy is high from the last item until the final result is issued.
// Reset clears all valid bits and restores the register defaults; results cannot be stalled.
`timescale 1ns / 1ps
module read_extent_coalescer
    import rec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [15:0]       slab_file,
    input  logic [47:0]       slab_offset,
    input  logic [31:0]       slab_length,
    input  logic [7:0]        slab_section,
    input  logic              last_slab,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              result_valid,
    output logic [5:0]        slab_index,
    output logic [5:0]        extent_index,
    output logic              extent_done,
    output logic [15:0]       extent_file,
    output logic [47:0]       extent_offset,
    output logic [48:0]       extent_size,
    output logic [54:0]       planned_bytes,
    output logic [54:0]       gap_total,
    output logic [37:0]       requested_bytes,
    output logic              last_result
);

    logic [47:0] max_gap_reg;
    logic [48:0] max_extent_reg;
    logic [29:0] submit_reg;
    logic [19:0] bw_reg;
    logic across_sec_reg, across_file_reg, one_per_reg;
    logic [THR_W-1:0] thr_reg;
    logic [19:0] bw_eff;

    top_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] settle_reg, settle_next;

    logic accept, store;
    plan_ctl_t ctl;
    plan_stat_t stat;
    cfg_t cfg;

    entry_t pass_w [0:MAX_SLABS];
    entry_t held_w [0:MAX_SLABS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg     <= 48'd262144;
            max_extent_reg  <= 49'd8388608;
            submit_reg      <= 30'd20000;
            bw_reg          <= 20'd3000;
            across_sec_reg  <= 1'b0;
            across_file_reg <= 1'b0;
            one_per_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAX_GAP:    max_gap_reg     <= cfg_data[47:0];
                REG_MAX_EXTENT: max_extent_reg  <= cfg_data[48:0];
                REG_SUBMIT:     submit_reg      <= cfg_data[29:0];
                REG_BANDWIDTH:  bw_reg          <= cfg_data[19:0];
                REG_ACROSS_SEC: across_sec_reg  <= cfg_data[0];
                REG_ACROSS_FIL: across_file_reg <= cfg_data[0];
                REG_ONE_PER:    one_per_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // cost threshold in byte-ns, recomputed every cycle; keeping config static while planning is up to the user
    assign bw_eff = (bw_reg == 20'd0) ? BW_DEFAULT : bw_reg;

    always_ff @(posedge clk)
    begin
        thr_reg <= THR_W'(submit_reg) * THR_W'(bw_eff);
    end

    assign cfg = '{max_gap: max_gap_reg, max_extent: max_extent_reg, cost_thr: thr_reg,
                   across_sec: across_sec_reg, across_file: across_file_reg,
                   one_per: one_per_reg};

    assign busy   = (state_reg != T_LOAD);
    assign accept = start && !busy;
    assign store  = accept && (count_reg < CNT_W'(MAX_SLABS));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        settle_next = settle_reg;
        ctl.go      = 1'b0;
        ctl.count   = count_reg;
        case (state_reg)
            T_LOAD:
            begin
                if (store)
                    count_next = count_reg + CNT_W'(1);
                if (accept && last_slab)
                begin
                    settle_next = '0;
                    state_next  = T_SETTLE;
                end
            end
            T_SETTLE:
            begin
                settle_next = settle_reg + CNT_W'(1);
                if (settle_reg == CNT_W'(MAX_SLABS))
                begin
                    ctl.go     = 1'b1;
                    count_next = '0;
                    state_next = T_PLAN;
                end
            end
            T_PLAN:
            begin
                if (stat.finish)
                    state_next = T_LOAD;
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_LOAD;
            count_reg  <= '0;
            settle_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            settle_reg <= settle_next;
        end
    end

    assign pass_w[0] = '{valid: store,
                         data: '{file: slab_file, offset: slab_offset, length: slab_length,
                                 section: slab_section, idx: IDX_W'(count_reg)}};
    assign held_w[MAX_SLABS] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_SLABS; g++)
        begin : g_cell
            rec_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (stat.pop),
                .in_left    (pass_w[g]),
                .from_right (held_w[g+1]),
                .held_out   (held_w[g]),
                .pass_out   (pass_w[g+1])
            );
        end
    endgenerate

    rec_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .cfg             (cfg),
        .head            (held_w[0].data),
        .stat            (stat),
        .result_valid    (result_valid),
        .slab_index      (slab_index),
        .extent_index    (extent_index),
        .extent_done     (extent_done),
        .extent_file     (extent_file),
        .extent_offset   (extent_offset),
        .extent_size     (extent_size),
        .planned_bytes   (planned_bytes),
        .gap_total       (gap_total),
        .requested_bytes (requested_bytes),
        .last_result     (last_result)
    );

    // the chain never holds more than MAX_SLABS items, so nothing leaves the far end
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !pass_w[MAX_SLABS].valid)
        else $error("item fell off the end of the sort chain");

    a_pop_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> (state_reg == T_PLAN) && held_w[0].valid)
        else $error("pop outside planning or from an empty chain");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |-> result_valid && extent_done)
        else $error("final result not closing an extent");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != T_LOAD) |-> !store)
        else $error("item stored while planning");

endmodule

@@ tb/testbench.sv @@
// Testbench for the read extent coalescer: predicted plans checked result by result.
`timescale 1ns / 1ps
module testbench;
    import rec_pkg::*;

    localparam int  SET_CAP     = 64;
    localparam int  RANDOM_GOAL = 280;
    localparam int  DRAIN_WAIT  = 12;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [5:0]  slab_index;
        logic [5:0]  extent_index;
        logic        extent_done;
        logic [15:0] extent_file;
        logic [47:0] extent_offset;
        logic [48:0] extent_size;
        logic [54:0] planned_bytes;
        logic [54:0] gap_total;
        logic [37:0] requested_bytes;
        logic        last_result;
    } extent_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [15:0]       slab_file;
    logic [47:0]       slab_offset;
    logic [31:0]       slab_length;
    logic [7:0]        slab_section;
    logic              last_slab;
    logic              cfg_write;
    logic [2:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              result_valid;
    logic [5:0]        slab_index;
    logic [5:0]        extent_index;
    logic              extent_done;
    logic [15:0]       extent_file;
    logic [47:0]       extent_offset;
    logic [48:0]       extent_size;
    logic [54:0]       planned_bytes;
    logic [54:0]       gap_total;
    logic [37:0]       requested_bytes;
    logic              last_result;

    read_extent_coalescer DUT (.*);

    // predictor state
    logic [47:0] cfg_gap;
    logic [48:0] cfg_ext;
    logic [29:0] cfg_cost;
    logic [19:0] cfg_bw;
    logic        cfg_sec;
    logic        cfg_fil;
    logic        cfg_one;
    logic [15:0] held_file [SET_CAP];
    logic [47:0] held_offset [SET_CAP];
    logic [31:0] held_length [SET_CAP];
    logic [7:0]  held_section [SET_CAP];
    int          held_count;

    extent_result_t pending_extents [$];
    int     errors;
    int     items_sent;
    int     plans_run;
    int     results_seen;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic gap_too_dear(logic [63:0] gap);
        logic [63:0] bw;
        bw = (cfg_bw == 0) ? 64'd3000 : 64'(cfg_bw);
        return gap * 64'd1000 >= 64'(cfg_cost) * bw;
    endfunction

    // Orders the held requests and queues one expected result per request.
    task automatic plan_extents();
        int          order [SET_CAP];
        int          n, i, j, k, v, ext_no, f, x;
        logic [63:0] planned, gaps, requested, first, size, stop, gap, nend;
        extent_result_t r;
        n = held_count;
        held_count = 0;
        ext_no = 0;
        planned = 0;
        gaps = 0;
        requested = 0;
        for (i = 0; i < n; i++)
        begin
            v = i;
            j = i;
            while (j > 0 && held_offset[order[j-1]] > held_offset[v])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
            requested += 64'(held_length[i]);
        end
        i = 0;
        while (i < n)
        begin
            f = order[i];
            first = 64'(held_offset[f]);
            size = 64'(held_length[f]);
            stop = first + size;
            j = i + 1;
            if (!cfg_one && size <= 64'(cfg_ext))
            begin
                while (j < n)
                begin
                    x = order[j];
                    if (!cfg_sec && held_section[x] != held_section[f]) break;
                    if (!cfg_fil && held_file[x] != held_file[f]) break;
                    gap = (64'(held_offset[x]) > stop) ? 64'(held_offset[x]) - stop : 0;
                    if (gap > 64'(cfg_gap)) break;
                    if (gap > 0 && gap_too_dear(gap)) break;
                    nend = 64'(held_offset[x]) + 64'(held_length[x]);
                    if (nend < stop) nend = stop;
                    if (nend - first > 64'(cfg_ext)) break;
                    stop = nend;
                    size = nend - first;
                    gaps += gap;
                    j++;
                end
            end
            planned += size;
            for (k = i; k < j; k++)
            begin
                r = '0;
                r.slab_index = 6'(order[k]);
                r.extent_index = 6'(ext_no);
                if (k + 1 == j)
                begin
                    r.extent_done = 1'b1;
                    r.extent_file = held_file[f];
                    r.extent_offset = first[47:0];
                    r.extent_size = size[48:0];
                end
                if (k == n - 1)
                begin
                    r.planned_bytes = planned[54:0];
                    r.gap_total = gaps[54:0];
                    r.requested_bytes = requested[37:0];
                    r.last_result = 1'b1;
                end
                pending_extents = {pending_extents, r};
            end
            ext_no++;
            i = j;
        end
        plans_run++;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        extent_result_t want;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (pending_extents.size() == 0)
            begin
                $display("%0t unexpected result: slab %0d", $time, slab_index);
                errors++;
            end
            else
            begin
                want = pending_extents.pop_front();
                check_field("slab_index", want.slab_index, slab_index);
                check_field("extent_index", want.extent_index, extent_index);
                check_field("extent_done", want.extent_done, extent_done);
                check_field("extent_file", want.extent_file, extent_file);
                check_field("extent_offset", want.extent_offset, extent_offset);
                check_field("extent_size", want.extent_size, extent_size);
                check_field("planned_bytes", want.planned_bytes, planned_bytes);
                check_field("gap_total", want.gap_total, gap_total);
                check_field("requested_bytes", want.requested_bytes, requested_bytes);
                check_field("last_result", want.last_result, last_result);
            end
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Called aligned to a clock edge; returns at the edge that accepts the item.
    task automatic send_slab(logic [15:0] fid, logic [47:0] off, logic [31:0] len,
                             logic [7:0] sec, logic last);
        int gap_cycles;
        gap_cycles = idle_gap();
        if (gap_cycles > 0)
        begin
            start <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        start <= 1'b1;
        slab_file <= fid;
        slab_offset <= off;
        slab_length <= len;
        slab_section <= sec;
        last_slab <= last;
        do @(posedge clk); while (busy);
        items_sent++;
        if (held_count < SET_CAP)
        begin
            held_file[held_count] = fid;
            held_offset[held_count] = off;
            held_length[held_count] = len;
            held_section[held_count] = sec;
            held_count++;
        end
        if (last) plan_extents();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_extents.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [63:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= v[CFG_W-1:0];
        case (r)
            REG_MAX_GAP:    cfg_gap = v[47:0];
            REG_MAX_EXTENT: cfg_ext = v[48:0];
            REG_SUBMIT:     cfg_cost = v[29:0];
            REG_BANDWIDTH:  cfg_bw = v[19:0];
            REG_ACROSS_SEC: cfg_sec = v[0];
            REG_ACROSS_FIL: cfg_fil = v[0];
            REG_ONE_PER:    cfg_one = v[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [63:0] gmax, logic [63:0] emax, logic [63:0] cost,
                              logic [63:0] bw, logic sec, logic fil, logic one);
        write_reg(REG_MAX_GAP, gmax);
        write_reg(REG_MAX_EXTENT, emax);
        write_reg(REG_SUBMIT, cost);
        write_reg(REG_BANDWIDTH, bw);
        write_reg(REG_ACROSS_SEC, 64'(sec));
        write_reg(REG_ACROSS_FIL, 64'(fil));
        write_reg(REG_ONE_PER, 64'(one));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_defaults();
        set_config(262144, 8388608, 20000, 3000, 0, 0, 0);
    endtask

    // Merging at reset values: overlap, equal offsets, section and file breaks, far gap.
    task automatic test_default_merge();
        send_slab(16'd7, 48'd10000, 32'd4096, 8'd1, 1'b0);
        send_slab(16'd7, 48'd0, 32'd4096, 8'd1, 1'b0);
        send_slab(16'd7, 48'd4096, 32'd100, 8'd1, 1'b0);
        send_slab(16'd7, 48'd4096, 32'd8192, 8'd1, 1'b0);
        send_slab(16'd7, 48'd5000, 32'd10, 8'd1, 1'b0);
        send_slab(16'd7, 48'd20000, 32'd64, 8'd2, 1'b0);
        send_slab(16'd8, 48'd20100, 32'd64, 8'd2, 1'b0);
        send_slab(16'd8, 48'd900000, 32'd0, 8'd2, 1'b1);
        wait_drained();
    endtask

    // Exact cost threshold: cost 2000 ns at 1 MB/s reads through one byte but not two.
    task automatic test_cost_edge();
        set_config(1000, 1000000, 2000, 1, 0, 0, 0);
        send_slab(16'd1, 48'd0, 32'd10, 8'd0, 1'b0);
        send_slab(16'd1, 48'd11, 32'd10, 8'd0, 1'b0);
        send_slab(16'd1, 48'd23, 32'd10, 8'd0, 1'b1);
        wait_drained();
        // zero bandwidth stands for 3000 MB/s
        set_config(1000, 1000000, 1, 0, 1, 1, 0);
        send_slab(16'd1, 48'd0, 32'd10, 8'd0, 1'b0);
        send_slab(16'd2, 48'd12, 32'd10, 8'd3, 1'b0);
        send_slab(16'd3, 48'd25, 32'd10, 8'd4, 1'b1);
        wait_drained();
    endtask

    // Oversized first request stands alone, extent limit stops later merges.
    task automatic test_extent_limit();
        set_config(64'hFFFF_FFFF_FFFF, 100, 1000000000, 1000000, 0, 0, 0);
        send_slab(16'hFFFF, 48'd0, 32'd101, 8'hFF, 1'b0);
        send_slab(16'hFFFF, 48'd101, 32'd5, 8'hFF, 1'b0);
        send_slab(16'hFFFF, 48'd200, 32'd50, 8'hFF, 1'b0);
        send_slab(16'hFFFF, 48'd250, 32'd50, 8'hFF, 1'b0);
        send_slab(16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_one_per_slab();
        set_config(64'hFFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF, 1000000000, 1000000, 1, 1, 1);
        send_slab(16'd3, 48'd0, 32'd8, 8'd0, 1'b0);
        send_slab(16'd3, 48'd8, 32'd8, 8'd0, 1'b0);
        send_slab(16'd3, 48'd100, 32'd8, 8'd0, 1'b1);
        wait_drained();
    endtask

    // Zero limits everywhere; a single request set as well.
    task automatic test_zero_limits();
        set_config(0, 0, 0, 0, 0, 0, 0);
        send_slab(16'd0, 48'd0, 32'd0, 8'd0, 1'b0);
        send_slab(16'd0, 48'd0, 32'd0, 8'd0, 1'b0);
        send_slab(16'd0, 48'd1, 32'd0, 8'd0, 1'b1);
        wait_drained();
        send_slab(16'd0, 48'd0, 32'd0, 8'd0, 1'b1);
        wait_drained();
    endtask

    // Full store: extra requests are dropped, the last one still plans.
    task automatic test_store_full();
        int i;
        set_defaults();
        for (i = 0; i < SET_CAP + 2; i++)
            send_slab(16'd4, 48'($urandom_range(0, 200000)), 32'($urandom_range(0, 3000)),
                      8'($urandom_range(0, 1)), i == SET_CAP + 1);
        wait_drained();
    endtask

    task automatic random_setting();
        case ($urandom_range(0, 5))
            0: set_defaults();
            1: set_config(64'hFFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF, 1000000000, 1000000,
                          1, 1, 0);
            2: set_config(0, 0, 0, 0, 0, 0, 0);
            3: set_config(64'({$urandom, $urandom}) & 64'hFFFF_FFFF_FFFF,
                          64'({$urandom, $urandom}) & 64'h1_FFFF_FFFF_FFFF,
                          64'($urandom_range(0, 1000000000)), 64'($urandom_range(0, 1000000)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            default: set_config(64'($urandom_range(0, 1 << 22)),
                                64'($urandom_range(0, 1 << 27)),
                                64'($urandom_range(0, 50000)), 64'($urandom_range(0, 5000)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 7) == 0);
        endcase
    endtask

    // Mostly clustered requests so merges happen; some fully random noise.
    task automatic test_random_plans();
        int          n, i, r;
        logic [63:0] base, span, off;
        logic [31:0] len;
        while (items_sent < RANDOM_GOAL)
        begin
            if ($urandom_range(0, 2) == 0) random_setting();
            r = $urandom_range(0, 19);
            n = (r < 16) ? $urandom_range(1, 10) : (r < 19) ? $urandom_range(11, 30)
                                                            : $urandom_range(31, 70);
            case ($urandom_range(0, 2))
                0: span = 64'd4096;
                1: span = 64'd1 << 20;
                default: span = 64'd1 << 26;
            endcase
            base = 64'($urandom) << 15;
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_slab(16'($urandom), 48'({$urandom, $urandom}), $urandom,
                              8'($urandom), i == n - 1);
                else
                begin
                    off = base + 64'($urandom) % span;
                    len = ($urandom_range(0, 15) == 0) ? 32'd0
                                                      : 32'(64'($urandom) % (span / 4)) + 1;
                    send_slab(16'($urandom_range(5, 6)), off[47:0], len,
                              8'($urandom_range(0, 1)), i == n - 1);
                end
            end
            wait_drained();
        end
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        plans_run = 0;
        results_seen = 0;
        cycles = 0;
        held_count = 0;
        cfg_gap = 48'd262144;
        cfg_ext = 49'd8388608;
        cfg_cost = 30'd20000;
        cfg_bw = 20'd3000;
        cfg_sec = 1'b0;
        cfg_fil = 1'b0;
        cfg_one = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        slab_file = '0;
        slab_offset = '0;
        slab_length = '0;
        slab_section = '0;
        last_slab = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_merge();
        test_cost_edge();
        test_extent_limit();
        test_one_per_slab();
        test_zero_limits();
        test_store_full();
        test_random_plans();

        $display("covered %0d requests in %0d plans, %0d results checked",
                 items_sent, plans_run, results_seen);
        $display("settings ranged from zero limits to full-width limits and per-slab mode");
        if (errors == 0 && pending_extents.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
